// File: design/descriptor_range_allocator_assert.svh
// Assertion macros for the descriptor range allocator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DESCRIPTOR_RANGE_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_RANGE_ALLOCATOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define DRA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define DRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dra_pkg.sv
// Shared types, sizes and codes of the descriptor range allocator.
// No dependencies; imported by the top level.
package dra_pkg;

  localparam int SLOTS    = 1024;
  localparam int RQ_DEPTH = 1024;
  localparam int WORD_W   = 8;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int WORDS    = SLOTS / WORD_W;
  localparam int WA_W     = $clog2(WORDS);
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int FENCE_W  = 64;
  localparam int STRIDE_W = 12;
  localparam int HANDLE_W = 64;
  localparam int QA_W     = $clog2(RQ_DEPTH);
  localparam int QN_W     = QA_W + 1;
  localparam int PROD_W   = IDX_W + STRIDE_W;
  localparam int IN_DW    = 88;
  localparam int OUT_DW   = 160;
  localparam int CFG_AW   = 6;
  localparam int CFG_DW   = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RETIRE  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BOP_FIND  = 2'd0,
    BOP_CHECK = 2'd1,
    BOP_SET   = 2'd2,
    BOP_CLEAR = 2'd3
  } bop_t;

  typedef enum logic [2:0] {
    REG_CAPACITY = 3'd0,
    REG_STRIDE   = 3'd1,
    REG_CPU_BASE = 3'd2,
    REG_GPU_BASE = 3'd3,
    REG_GPU_VIS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [FENCE_W-1:0] fence;
  } rq_entry_t;

  // bitmap word that holds a given slot
  function automatic logic [WA_W-1:0] word_of(logic [CNT_W-1:0] s);
    return s[BIT_W +: WA_W];
  endfunction

endpackage

// File: design/descriptor_range_allocator.sv
// Top level of the descriptor range allocator: slot bitmap, retire queue,
// command sequencer and handle arithmetic. Depends on dra_pkg and the assert header.
//
//  channel | direction | fields
//  in_     | slave     | tuser: cmd; tdata: range_index, range_count, fence
//  out_    | master    | tuser: ok; tdata: got_index, got_count, handles, used_slots
//  cfg_    | APB       | 0 capacity, 1 stride, 2 cpu base, 3 gpu base, 4 gpu visible
//
// One item at a time. A bitmap word or a queue entry is read, then used. Allocate
// scans words for a first-fit run, marks its words, then forms the handles; a
// rejected command goes straight to its result. Free checks its words, walks the
// queue, then clears its words; retire the same without clearing. Release walks the
// queue and checks, then clears, each range it frees. A held result blocks in_tready
// once the next is ready. Reset and any capacity write clear all 128 bitmap words.
`include "descriptor_range_allocator_assert.svh"

module descriptor_range_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dra_pkg::IN_DW-1:0]    in_tdata,   // range_index, range_count, fence
  input  logic [1:0]                   in_tuser,   // cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dra_pkg::OUT_DW-1:0]   out_tdata,  // got_index, got_count, cpu_handle,
                                                   // gpu_handle, used_slots
  output logic                         out_tuser,  // ok
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dra_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dra_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dra_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import dra_pkg::*;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_DISP = 10'b0000000100,
    S_BRD  = 10'b0000001000,
    S_BOP  = 10'b0000010000,
    S_QRD  = 10'b0000100000,
    S_QOP  = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_SUM  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  // memories
  logic [WORD_W-1:0] bm_mem [WORDS];
  rq_entry_t         rq_mem [RQ_DEPTH];
  logic [WORD_W-1:0] bm_rdata_r;
  rq_entry_t         rq_rdata_r;
  logic              bm_we;
  logic [WORD_W-1:0] bm_wdata;
  logic              rq_we;
  logic [QA_W-1:0]   rq_waddr;
  rq_entry_t         rq_wdata;

  // control and payload registers
  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FENCE_W-1:0]   fence_r, fence_nxt;
  logic [CNT_W-1:0]     cap_r, cap_nxt;
  logic [STRIDE_W-1:0]  stride_r, stride_nxt;
  logic [HANDLE_W-1:0]  cpu_base_r, cpu_base_nxt;
  logic [HANDLE_W-1:0]  gpu_base_r, gpu_base_nxt;
  logic                 vis_r, vis_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [QN_W-1:0]      rq_n_r, rq_n_nxt;
  logic [QN_W-1:0]      qi_r, qi_nxt;
  logic [QN_W-1:0]      qw_r, qw_nxt;
  bop_t                 bop_r, bop_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [WA_W-1:0]      word_r, word_nxt;
  logic [CNT_W-1:0]     run_len_r, run_len_nxt;
  logic [IDX_W-1:0]     run_start_r, run_start_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]     res_gi_r, res_gi_nxt;
  logic [CNT_W-1:0]     res_gc_r, res_gc_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [HANDLE_W-1:0]  cpu_h_r, cpu_h_nxt;
  logic [HANDLE_W-1:0]  gpu_h_r, gpu_h_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [OUT_DW-1:0]    out_data_r, out_data_nxt;

  logic                 cfg_wr;
  reg_idx_t             cfg_reg;
  logic                 in_acc;
  logic [WA_W-1:0]      last_word;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_reg    = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;
  assign last_word  = word_of(hi_r - CNT_W'(1));

  // register readback
  always_comb begin
    cfg_prdata = '0;
    case (cfg_reg)
      REG_CAPACITY: cfg_prdata = CFG_DW'(cap_r);
      REG_STRIDE:   cfg_prdata = CFG_DW'(stride_r);
      REG_CPU_BASE: cfg_prdata = cpu_base_r;
      REG_GPU_BASE: cfg_prdata = gpu_base_r;
      REG_GPU_VIS:  cfg_prdata = CFG_DW'(vis_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    logic [CNT_W-1:0]  s;
    logic              inr;
    logic              chk_fail;
    logic              found;
    logic [CNT_W-1:0]  rl;
    logic [IDX_W-1:0]  rs;
    logic [IDX_W-1:0]  fs;
    logic [WORD_W-1:0] nw;
    logic              range_ok;
    logic              is_last;
    logic [CNT_W-1:0]  cap_w;
    rq_entry_t         e;

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    fence_nxt     = fence_r;
    cap_nxt       = cap_r;
    stride_nxt    = stride_r;
    cpu_base_nxt  = cpu_base_r;
    gpu_base_nxt  = gpu_base_r;
    vis_nxt       = vis_r;
    used_nxt      = used_r;
    rq_n_nxt      = rq_n_r;
    qi_nxt        = qi_r;
    qw_nxt        = qw_r;
    bop_nxt       = bop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    word_nxt      = word_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    res_ok_nxt    = res_ok_r;
    res_gi_nxt    = res_gi_r;
    res_gc_nxt    = res_gc_r;
    prod_nxt      = prod_r;
    cpu_h_nxt     = cpu_h_r;
    gpu_h_nxt     = gpu_h_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    bm_we         = 1'b0;
    bm_wdata      = '0;
    rq_we         = 1'b0;
    rq_waddr      = qw_r[QA_W-1:0];
    rq_wdata      = rq_rdata_r;
    e             = rq_rdata_r;
    cap_w         = '0;

    // word scan: check, mark and first-fit run tracking over one bitmap word
    chk_fail = 1'b0;
    found    = 1'b0;
    rl       = run_len_r;
    rs       = run_start_r;
    fs       = '0;
    nw       = bm_rdata_r;
    for (int j = 0; j < WORD_W; j++) begin
      s   = CNT_W'({word_r, BIT_W'(j)});
      inr = (s >= lo_r) && (s < hi_r);
      if (inr && !bm_rdata_r[j]) chk_fail = 1'b1;
      if (inr) nw[j] = (bop_r == BOP_SET);
      if (!found) begin
        if (inr && !bm_rdata_r[j]) begin
          if (rl == '0) rs = s[IDX_W-1:0];
          rl = rl + CNT_W'(1);
          if (rl == cnt_r) begin
            found = 1'b1;
            fs    = rs;
          end
        end else begin
          rl = '0;
        end
      end
    end
    is_last = (word_r == last_word);

    range_ok = (cap_r != '0) && (cnt_r != '0) && ({1'b0, idx_r} < cap_r) &&
               (cnt_r <= cap_r - {1'b0, idx_r});

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      // bitmap clearing pass
      S_CLR: begin
        bm_we    = 1'b1;
        bm_wdata = '0;
        if (word_r == WA_W'(WORDS - 1)) state_nxt = S_IDLE;
        else word_nxt = word_r + WA_W'(1);
      end

      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = cmd_t'(in_tuser);
          idx_nxt    = in_tdata[IDX_W-1:0];
          cnt_nxt    = in_tdata[IDX_W +: CNT_W];
          fence_nxt  = in_tdata[IDX_W + CNT_W +: FENCE_W];
          res_ok_nxt = 1'b0;
          res_gi_nxt = '0;
          res_gc_nxt = '0;
          cpu_h_nxt  = '0;
          gpu_h_nxt  = '0;
          state_nxt  = S_DISP;
        end
      end

      // argument checks and first step of each command
      S_DISP: begin
        bop_nxt     = BOP_CHECK;
        lo_nxt      = {1'b0, idx_r};
        hi_nxt      = {1'b0, idx_r} + cnt_r;
        word_nxt    = word_of({1'b0, idx_r});
        run_len_nxt = '0;
        qi_nxt      = '0;
        qw_nxt      = '0;
        case (cmd_r)
          CMD_ALLOC: begin
            bop_nxt  = BOP_FIND;
            lo_nxt   = '0;
            hi_nxt   = cap_r;
            word_nxt = '0;
            state_nxt = ((cap_r == '0) || (cnt_r == '0)) ? S_DONE : S_BRD;
          end
          CMD_FREE:   state_nxt = range_ok ? S_BRD : S_DONE;
          CMD_RETIRE: begin
            state_nxt = (range_ok && (fence_r != '0) && (rq_n_r != QN_W'(RQ_DEPTH)))
                        ? S_BRD : S_DONE;
          end
          CMD_RELEASE: state_nxt = S_QRD;
          default:     state_nxt = S_DONE;
        endcase
      end

      S_BRD: state_nxt = S_BOP;

      // scan, check or modify one bitmap word and decide what follows
      S_BOP: begin
        state_nxt = S_BRD;
        word_nxt  = word_r + WA_W'(1);
        case (bop_r)
          BOP_FIND: begin
            run_len_nxt   = rl;
            run_start_nxt = rs;
            if (found) begin
              res_gi_nxt = fs;
              res_gc_nxt = cnt_r;
              bop_nxt    = BOP_SET;
              lo_nxt     = {1'b0, fs};
              hi_nxt     = {1'b0, fs} + cnt_r;
              word_nxt   = word_of({1'b0, fs});
            end else if (is_last) begin
              state_nxt = S_DONE;
            end
          end
          BOP_CHECK: begin
            if (chk_fail) begin
              state_nxt = (cmd_r == CMD_RELEASE) ? S_QRD : S_DONE;
            end else if (is_last) begin
              if (cmd_r == CMD_RELEASE) begin
                bop_nxt  = BOP_CLEAR;
                word_nxt = word_of(lo_r);
              end else begin
                qi_nxt    = '0;
                state_nxt = S_QRD;
              end
            end
          end
          default: begin
            bm_we    = 1'b1;
            bm_wdata = nw;
            if (is_last) begin
              if (bop_r == BOP_SET) begin
                used_nxt   = used_r + (hi_r - lo_r);
                res_ok_nxt = 1'b1;
                state_nxt  = S_MUL;
              end else begin
                used_nxt = used_r - (hi_r - lo_r);
                if (cmd_r == CMD_RELEASE) begin
                  state_nxt = S_QRD;
                end else begin
                  res_ok_nxt = 1'b1;
                  state_nxt  = S_DONE;
                end
              end
            end
          end
        endcase
      end

      // retire queue walk: end of queue or fetch next entry
      S_QRD: begin
        if (qi_r == rq_n_r) begin
          case (cmd_r)
            CMD_RELEASE: begin
              rq_n_nxt   = qw_r;
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
            CMD_FREE: begin
              bop_nxt   = BOP_CLEAR;
              word_nxt  = word_of(lo_r);
              state_nxt = S_BRD;
            end
            default: begin
              rq_we      = 1'b1;
              rq_waddr   = rq_n_r[QA_W-1:0];
              rq_wdata   = '{idx: idx_r, cnt: cnt_r, fence: fence_r};
              rq_n_nxt   = rq_n_r + QN_W'(1);
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
          endcase
        end else begin
          state_nxt = S_QOP;
        end
      end

      S_QOP: begin
        qi_nxt    = qi_r + QN_W'(1);
        state_nxt = S_QRD;
        if (cmd_r == CMD_RELEASE) begin
          if (e.fence > fence_r) begin
            // still pending: compact toward the head
            rq_we    = 1'b1;
            rq_waddr = qw_r[QA_W-1:0];
            rq_wdata = e;
            qw_nxt   = qw_r + QN_W'(1);
          end else begin
            bop_nxt   = BOP_CHECK;
            lo_nxt    = {1'b0, e.idx};
            hi_nxt    = {1'b0, e.idx} + e.cnt;
            word_nxt  = word_of({1'b0, e.idx});
            state_nxt = S_BRD;
          end
        end else if ((e.idx == idx_r) && (e.cnt == cnt_r)) begin
          state_nxt = S_DONE;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(res_gi_r) * PROD_W'(stride_r);
        state_nxt = S_SUM;
      end

      S_SUM: begin
        cpu_h_nxt = cpu_base_r + HANDLE_W'(prod_r);
        gpu_h_nxt = vis_r ? (gpu_base_r + HANDLE_W'(prod_r)) : '0;
        state_nxt = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_data_nxt  = {used_r, gpu_h_r, cpu_h_r, res_gc_r, res_gi_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // configuration writes; capacity reinitializes the store
    if (cfg_wr) begin
      case (cfg_reg)
        REG_CAPACITY: begin
          cap_w     = cfg_pwdata[CNT_W-1:0];
          cap_nxt   = (cap_w > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cap_w;
          used_nxt  = '0;
          rq_n_nxt  = '0;
          word_nxt  = '0;
          state_nxt = S_CLR;
        end
        REG_STRIDE:   stride_nxt   = cfg_pwdata[STRIDE_W-1:0];
        REG_CPU_BASE: cpu_base_nxt = cfg_pwdata;
        REG_GPU_BASE: gpu_base_nxt = cfg_pwdata;
        REG_GPU_VIS:  vis_nxt      = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // memories: registered read
  always_ff @(posedge clk) begin
    bm_rdata_r <= bm_mem[word_r];
    if (bm_we) bm_mem[word_r] <= bm_wdata;
  end

  always_ff @(posedge clk) begin
    rq_rdata_r <= rq_mem[qi_r[QA_W-1:0]];
    if (rq_we) rq_mem[rq_waddr] <= rq_wdata;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      word_r      <= '0;
      cap_r       <= CNT_W'(SLOTS);
      stride_r    <= STRIDE_W'(32);
      cpu_base_r  <= '0;
      gpu_base_r  <= '0;
      vis_r       <= 1'b0;
      used_r      <= '0;
      rq_n_r      <= '0;
      qi_r        <= '0;
      qw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      cap_r       <= cap_nxt;
      stride_r    <= stride_nxt;
      cpu_base_r  <= cpu_base_nxt;
      gpu_base_r  <= gpu_base_nxt;
      vis_r       <= vis_nxt;
      used_r      <= used_nxt;
      rq_n_r      <= rq_n_nxt;
      qi_r        <= qi_nxt;
      qw_r        <= qw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    fence_r     <= fence_nxt;
    bop_r       <= bop_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    run_len_r   <= run_len_nxt;
    run_start_r <= run_start_nxt;
    res_ok_r    <= res_ok_nxt;
    res_gi_r    <= res_gi_nxt;
    res_gc_r    <= res_gc_nxt;
    prod_r      <= prod_nxt;
    cpu_h_r     <= cpu_h_nxt;
    gpu_h_r     <= gpu_h_nxt;
    out_ok_r    <= out_ok_nxt;
    out_data_r  <= out_data_nxt;
  end

  // checks
  `DRA_ASSERT_ALWAYS(a_used_bound, used_r <= cap_r, "used slots exceed capacity")
  `DRA_ASSERT_ALWAYS(a_rq_bound, rq_n_r <= QN_W'(RQ_DEPTH), "retire queue overflow")
  `DRA_ASSERT_ALWAYS(a_compact_behind, qw_r <= qi_r, "queue compaction overtook read")
  `DRA_ASSERT_NEXT(a_busy_after_accept, in_acc && !cfg_wr, !in_tready, "ready while busy")
  `DRA_ASSERT_NEXT(a_cap_clears, cfg_wr && (cfg_reg == REG_CAPACITY), state_r == S_CLR,
                   "capacity write did not start clearing pass")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for descriptor_range_allocator: stream commands in,
// predicted grant/free/retire/release results compared item by item.
// Depends on dra_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import dra_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    bit           ok;
    logic [9:0]   got_index;
    logic [10:0]  got_count;
    logic [63:0]  cpu_handle;
    logic [63:0]  gpu_handle;
    logic [10:0]  used_slots;
  } grant_t;

  typedef struct {
    int unsigned idx;
    int unsigned cnt;
  } span_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;   // range_index, range_count, fence
  logic [1:0]          in_tuser = '0;   // cmd
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;       // got_index, got_count, cpu_handle, gpu_handle, used_slots
  logic                out_tuser;       // ok
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  descriptor_range_allocator u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- allocator shadow ----------------
  int unsigned  sh_cap, sh_stride;
  logic [63:0]  sh_cpu_base, sh_gpu_base;
  bit           sh_visible;
  int unsigned  fr_first[SLOTS], fr_len[SLOTS], fr_n;
  bit           slot_busy[SLOTS];
  int unsigned  fq_idx[RQ_DEPTH], fq_cnt[RQ_DEPTH], fq_n;
  logic [63:0]  fq_fence[RQ_DEPTH];
  int unsigned  busy_total;

  grant_t       grants_due[$];
  span_t        live_spans[$];
  int           mismatches = 0;
  int           n_items = 0, n_results = 0, n_ok = 0;
  int           hold_cycles = 0;

  function automatic void store_reinit();
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    fr_n = 0;
    if (sh_cap != 0) begin
      fr_first[0] = 0;
      fr_len[0] = sh_cap;
      fr_n = 1;
    end
    fq_n = 0;
    busy_total = 0;
    live_spans.delete();
  endfunction

  function automatic bit span_busy(int unsigned idx, int unsigned cnt);
    if (sh_cap == 0 || cnt == 0 || idx >= sh_cap || cnt > sh_cap - idx) return 1'b0;
    for (int unsigned i = idx; i < idx + cnt; i++)
      if (!slot_busy[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit span_fenced(int unsigned idx, int unsigned cnt);
    for (int unsigned i = 0; i < fq_n; i++)
      if (fq_idx[i] == idx && fq_cnt[i] == cnt) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_free_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fr_n; i++) begin
      fr_first[i] = fr_first[i+1];
      fr_len[i] = fr_len[i+1];
    end
    fr_n--;
  endfunction

  // return a span to the sorted free list, merging with both neighbors
  function automatic bit span_return(int unsigned idx, int unsigned cnt);
    int unsigned pos;
    if (!span_busy(idx, cnt) || fr_n >= SLOTS) return 1'b0;
    for (int unsigned i = idx; i < idx + cnt; i++) slot_busy[i] = 1'b0;
    busy_total -= cnt;
    pos = 0;
    while (pos < fr_n && fr_first[pos] < idx) pos++;
    for (int unsigned i = fr_n; i > pos; i--) begin
      fr_first[i] = fr_first[i-1];
      fr_len[i] = fr_len[i-1];
    end
    fr_first[pos] = idx;
    fr_len[pos] = cnt;
    fr_n++;
    if (pos > 0 && fr_first[pos-1] + fr_len[pos-1] == fr_first[pos]) begin
      fr_len[pos-1] += fr_len[pos];
      drop_free_entry(pos);
      pos--;
    end
    if (pos + 1 < fr_n && fr_first[pos] + fr_len[pos] == fr_first[pos+1]) begin
      fr_len[pos] += fr_len[pos+1];
      drop_free_entry(pos + 1);
    end
    return 1'b1;
  endfunction

  function automatic grant_t apply_command(cmd_t cmd, int unsigned idx, int unsigned cnt,
                                           logic [63:0] fence);
    grant_t g;
    int unsigned b, i;
    g = '{default: 0};
    case (cmd)
      CMD_ALLOC: begin
        if (sh_cap != 0 && cnt != 0) begin
          for (i = 0; i < fr_n; i++) begin
            if (fr_len[i] < cnt) continue;
            b = fr_first[i];
            fr_first[i] += cnt;
            fr_len[i] -= cnt;
            if (fr_len[i] == 0) drop_free_entry(i);
            for (int unsigned k = b; k < b + cnt; k++) slot_busy[k] = 1'b1;
            busy_total += cnt;
            g.ok = 1'b1;
            g.got_index = b[9:0];
            g.got_count = cnt[10:0];
            g.cpu_handle = sh_cpu_base + 64'(b) * 64'(sh_stride);
            g.gpu_handle = sh_visible ? sh_gpu_base + 64'(b) * 64'(sh_stride) : 64'd0;
            live_spans.insert(live_spans.size(), '{b, cnt});
            break;
          end
        end
      end
      CMD_FREE: begin
        if (span_busy(idx, cnt) && !span_fenced(idx, cnt)) g.ok = span_return(idx, cnt);
      end
      CMD_RETIRE: begin
        if (span_busy(idx, cnt) && fence != 0 && !span_fenced(idx, cnt) &&
            fq_n < RQ_DEPTH) begin
          fq_idx[fq_n] = idx;
          fq_cnt[fq_n] = cnt;
          fq_fence[fq_n] = fence;
          fq_n++;
          g.ok = 1'b1;
        end
      end
      default: begin
        // completed fences free in queue order; stale entries just vanish
        i = 0;
        while (i < fq_n) begin
          int unsigned ri, rc;
          if (fq_fence[i] > fence) begin
            i++;
            continue;
          end
          ri = fq_idx[i];
          rc = fq_cnt[i];
          for (int unsigned k = i; k + 1 < fq_n; k++) begin
            fq_idx[k] = fq_idx[k+1];
            fq_cnt[k] = fq_cnt[k+1];
            fq_fence[k] = fq_fence[k+1];
          end
          fq_n--;
          void'(span_return(ri, rc));
        end
        g.ok = 1'b1;
      end
    endcase
    g.used_slots = busy_total[10:0];
    return g;
  endfunction

  // ---------------- input side ----------------
  int burst_left = 0;

  // entered and left at a falling edge; valid stays high after acceptance
  task automatic send_cmd(cmd_t cmd, int unsigned idx, int unsigned cnt, logic [63:0] fence);
    if (burst_left == 0) begin
      int gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b0, fence, cnt[10:0], idx[9:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    grants_due.insert(grants_due.size(), apply_command(cmd, idx, cnt, fence));
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [63:0] value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'(r) << 3;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (r)
      REG_CAPACITY: begin
        sh_cap = (value[10:0] > SLOTS) ? SLOTS : int'(value[10:0]);
        store_reinit();
      end
      REG_STRIDE:   sh_stride = value[11:0];
      REG_CPU_BASE: sh_cpu_base = value;
      REG_GPU_BASE: sh_gpu_base = value;
      default:      sh_visible = value[0];
    endcase
  endtask

  // ---------------- output side ----------------
  int rx_mode = 0, rx_phase = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) rx_mode <= $urandom_range(0, 3);
      rx_phase <= (rx_phase + 1) % 150;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= $urandom_range(0, 7) != 0;
        default: out_tready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      grant_t e;
      n_results++;
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result item %h ok=%b",
                                       out_tdata, out_tuser);
      end else begin
        e = grants_due.pop_front();
        if (e.ok) n_ok++;
        if (out_tuser !== e.ok || out_tdata[9:0] !== e.got_index ||
            out_tdata[20:10] !== e.got_count || out_tdata[84:21] !== e.cpu_handle ||
            out_tdata[148:85] !== e.gpu_handle || out_tdata[159:149] !== e.used_slots) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d exp ok=%b idx=%0d cnt=%0d cpu=%h gpu=%h used=%0d",
                     n_results, e.ok, e.got_index, e.got_count, e.cpu_handle,
                     e.gpu_handle, e.used_slots);
            $display("       got ok=%b idx=%0d cnt=%0d cpu=%h gpu=%h used=%0d",
                     out_tuser, out_tdata[9:0], out_tdata[20:10], out_tdata[84:21],
                     out_tdata[148:85], out_tdata[159:149]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------- tests ----------------
  localparam logic [63:0] ALL_ONES = '1;

  task automatic test_basic_commands();
    send_cmd(CMD_ALLOC, 0, 0, 0);             // zero count
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_ALLOC, 0, 1024, 0);          // no room
    send_cmd(CMD_ALLOC, 0, 2047, 0);          // beyond the store
    send_cmd(CMD_FREE, 0, 1, 0);
    send_cmd(CMD_ALLOC, 0, 1024, 0);          // whole store
    send_cmd(CMD_FREE, 1023, 2, 0);           // runs off the end
    send_cmd(CMD_FREE, 0, 0, 0);
    send_cmd(CMD_RETIRE, 0, 16, 0);           // zero fence
    send_cmd(CMD_RETIRE, 0, 16, ALL_ONES);
    send_cmd(CMD_RETIRE, 0, 16, 5);           // already queued
    send_cmd(CMD_FREE, 0, 16, 0);             // queued, cannot free
    send_cmd(CMD_RELEASE, 0, 0, ALL_ONES - 1);
    send_cmd(CMD_RELEASE, 1023, 2047, ALL_ONES);
    send_cmd(CMD_FREE, 16, 1008, 0);
    send_cmd(CMD_FREE, 16, 8, 0);             // already free
  endtask

  task automatic test_handles();
    write_reg(REG_STRIDE, 4095);
    write_reg(REG_CPU_BASE, ALL_ONES - 100);
    write_reg(REG_GPU_BASE, 64'h8000_0000_0000_0000);
    write_reg(REG_GPU_VIS, 1);
    send_cmd(CMD_ALLOC, 0, 1000, 0);
    send_cmd(CMD_ALLOC, 0, 23, 0);            // lands at 1000, handles wrap
    send_cmd(CMD_FREE, 0, 1000, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    write_reg(REG_GPU_VIS, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    write_reg(REG_STRIDE, 0);
    send_cmd(CMD_ALLOC, 0, 3, 0);
  endtask

  task automatic test_capacity_edges();
    write_reg(REG_CAPACITY, 0);               // nothing managed
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_FREE, 0, 1, 0);
    send_cmd(CMD_RETIRE, 0, 1, 1);
    send_cmd(CMD_RELEASE, 0, 0, ALL_ONES);
    write_reg(REG_CAPACITY, 2047);            // saturates to the slot count
    send_cmd(CMD_ALLOC, 0, 1024, 0);
    write_reg(REG_CAPACITY, 1);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_FREE, 1, 1, 0);              // index past capacity
    // queued span partly freed before its fence completes
    write_reg(REG_CAPACITY, 16);
    send_cmd(CMD_ALLOC, 0, 4, 0);
    send_cmd(CMD_RETIRE, 0, 4, 5);
    send_cmd(CMD_FREE, 0, 2, 0);
    send_cmd(CMD_RELEASE, 0, 0, 5);
    send_cmd(CMD_ALLOC, 0, 16, 0);
  endtask

  // fences fall along the queue, so a partial release frees its back half
  task automatic test_retire_queue();
    write_reg(REG_CAPACITY, 64);
    send_cmd(CMD_ALLOC, 0, 64, 0);
    for (int unsigned i = 0; i < 64; i++)
      send_cmd(CMD_RETIRE, i, (i % 3 == 2) ? 2 : 1, 64'(64 - i));
    send_cmd(CMD_RELEASE, 0, 0, 32);
    send_cmd(CMD_RELEASE, 0, 0, ALL_ONES);
  endtask

  task automatic random_item(logic [63:0] now);
    int r = $urandom_range(0, 99);
    int unsigned idx, cnt, k;
    logic [63:0] fence;
    idx = $urandom_range(0, 1023);
    cnt = $urandom_range(0, 2047);
    if (live_spans.size() != 0 && $urandom_range(0, 6) != 0) begin
      k = $urandom_range(0, live_spans.size() - 1);
      idx = live_spans[k].idx;
      cnt = live_spans[k].cnt;
    end else k = ~0;
    case ($urandom_range(0, 5))
      0: fence = {$urandom, $urandom};
      1: fence = $urandom_range(0, 2) == 0 ? 64'd0 : ALL_ONES;
      default: fence = now + $urandom_range(1, 40);
    endcase
    if (r < 42) begin
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(0, 2047);
        1: cnt = $urandom_range(1, sh_cap + 2);
        default: cnt = $urandom_range(1, 8);
      endcase
      send_cmd(CMD_ALLOC, idx, cnt, fence);
    end else if (r < 68) begin
      if (k != ~0) live_spans.delete(k);
      send_cmd(CMD_FREE, idx, cnt, fence);
    end else if (r < 88) begin
      send_cmd(CMD_RETIRE, idx, cnt, fence);
    end else begin
      send_cmd(CMD_RELEASE, idx, cnt, $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : now);
    end
  endtask

  task automatic test_random_traffic();
    logic [63:0] now;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(REG_CAPACITY, 48);
        1: write_reg(REG_CAPACITY, 1024);
        2: write_reg(REG_CAPACITY, 2);
        3: write_reg(REG_CAPACITY, $urandom_range(3, 200));
        default: write_reg(REG_CAPACITY, $urandom_range(0, 2047));
      endcase
      write_reg(REG_STRIDE, ph == 2 ? 4095 : $urandom_range(0, 4095));
      write_reg(REG_CPU_BASE, ph == 1 ? ALL_ONES : {$urandom, $urandom});
      write_reg(REG_GPU_BASE, {$urandom, $urandom});
      write_reg(REG_GPU_VIS, ph % 2);
      now = 0;
      for (int n = 0; n < 75; n++) begin
        if (ph == 1 && n == 30) hold_cycles = 400;   // receiver backs up the block
        if (ph == 3 && n == 40) wait_drained();       // sender pauses until all are back
        now += $urandom_range(0, 6);
        random_item(now);
      end
    end
  endtask

  initial begin
    sh_cap = SLOTS;
    sh_stride = 32;
    sh_cpu_base = 0;
    sh_gpu_base = 0;
    sh_visible = 0;
    store_reinit();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_commands();
    test_handles();
    test_capacity_edges();
    test_retire_queue();
    test_random_traffic();

    wait_drained();
    repeat (100) @(negedge clk);
    $display("Sent %0d commands (alloc/free/retire/release over 6 capacity settings),",
             n_items);
    $display("checked %0d results, %0d succeeded, %0d mismatches.", n_results, n_ok,
             mismatches);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
